// File: rtl/kwsrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwsrm_pkg
// Shared types and constants for the k-way sorted run merge block.
// ----------------------------------------------------------------------------
package kwsrm_pkg;

  localparam int KEY_W         = 32;
  localparam int OP_W          = 2;
  localparam int SEL_W         = 3;
  localparam int OUT_RUN_W     = 3;
  localparam int ACT_W         = 4;

  localparam int RUNS_DEF      = 8;
  localparam int RUN_DEPTH_DEF = 256;

  localparam logic [ACT_W-1:0] ACTIVE_RUNS_RESET = 4'd8;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

endpackage

// File: rtl/kway_sorted_run_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kway_sorted_run_merge
// Holds RUNS sorted runs of signed Q16.16 keys and merges them on pop.
// ----------------------------------------------------------------------------
// A load appends a key to one run, or flags load_overflow when the run is
// full or out of range. On a pop the heads of the active runs, active_runs
// clamped to RUNS, are read one per cycle through the single read port of the
// key memory and fed to one signed comparator; the scan state finishes the
// last compare and the finish state updates the read index and loads the
// result register. Ties go to the lowest run. The input side takes a new
// item while the previous result still waits in the output register.
// Key memory entries are undefined until written; only written entries are
// ever taken as candidates.
// ----------------------------------------------------------------------------
module kway_sorted_run_merge #(
  parameter int RUNS      = kwsrm_pkg::RUNS_DEF,
  parameter int RUN_DEPTH = kwsrm_pkg::RUN_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                cfg_we,
  input  logic [kwsrm_pkg::ACT_W-1:0]         cfg_wdata,

  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [kwsrm_pkg::OP_W-1:0]          in_operation,
  input  logic [kwsrm_pkg::SEL_W-1:0]         in_run_select,
  input  logic signed [kwsrm_pkg::KEY_W-1:0]  in_key_value,

  output logic                                out_result_valid,
  input  logic                                out_result_ready,
  output logic signed [kwsrm_pkg::KEY_W-1:0]  out_value,
  output logic [kwsrm_pkg::OUT_RUN_W-1:0]     out_run,
  output logic                                out_valid,
  output logic                                out_load_overflow
);

  localparam int RW        = $clog2(RUNS);
  localparam int IW        = $clog2(RUN_DEPTH);
  localparam int CW        = $clog2(RUN_DEPTH + 1);
  localparam int AW        = RW + IW;
  localparam int MEM_DEPTH = RUNS * (2 ** IW);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [kwsrm_pkg::ACT_W-1:0]        active_runs_r;
  kwsrm_pkg::op_t                     op_r;
  logic [kwsrm_pkg::SEL_W-1:0]        sel_r;
  logic [kwsrm_pkg::KEY_W-1:0]        key_r;

  logic [CW-1:0]                      fill_r    [RUNS];
  logic [CW-1:0]                      rd_idx_r  [RUNS];

  logic [RW:0]                        scan_r;
  logic [RW:0]                        n_r;
  logic                               cand_vld_r;
  logic [RW-1:0]                      cand_run_r;
  logic                               found_r;
  logic [RW-1:0]                      best_run_r;
  logic [kwsrm_pkg::KEY_W-1:0]        best_key_r;

  logic [kwsrm_pkg::KEY_W-1:0]        mem [MEM_DEPTH];
  logic [kwsrm_pkg::KEY_W-1:0]        rd_data_r;
  logic [AW-1:0]                      rd_addr;
  logic                               mem_we;
  logic [AW-1:0]                      wr_addr;

  logic                               in_xfer;
  logic                               out_free;
  logic                               scan_busy;
  logic [RW-1:0]                      scan_run;
  logic                               head_elig;
  logic                               take_cand;
  logic                               sel_ok;
  logic [RW-1:0]                      sel_run;
  logic                               run_full;
  logic                               load_ok;
  logic [RW:0]                        n_start;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_result_valid || out_result_ready;

  // number of runs scanned, active_runs clamped to RUNS
  assign n_start = (32'(active_runs_r) > RUNS) ? (RW+1)'(RUNS) : (RW+1)'(active_runs_r);

  assign scan_busy = (state_r == S_SCAN) && (scan_r < n_r);
  assign scan_run  = scan_r[RW-1:0];
  assign head_elig = rd_idx_r[scan_run] < fill_r[scan_run];
  assign rd_addr   = {scan_run, rd_idx_r[scan_run][IW-1:0]};

  // strict compare keeps the lowest run on a tie
  assign take_cand = cand_vld_r &&
                     (!found_r || ($signed(rd_data_r) < $signed(best_key_r)));

  assign sel_ok   = 32'(sel_r) < RUNS;
  assign sel_run  = RW'(sel_r);
  assign run_full = sel_ok ? (fill_r[sel_run] >= CW'(RUN_DEPTH)) : 1'b1;
  assign load_ok  = sel_ok && !run_full;
  assign wr_addr  = {sel_run, fill_r[sel_run][IW-1:0]};
  assign mem_we   = (state_r == S_FINISH) && out_free && (op_r == kwsrm_pkg::OP_LOAD) &&
                    load_ok;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (kwsrm_pkg::op_t'(in_operation) == kwsrm_pkg::OP_POP) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        if (scan_r == n_r) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      active_runs_r <= kwsrm_pkg::ACTIVE_RUNS_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        active_runs_r <= cfg_wdata;
      end
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r  <= kwsrm_pkg::op_t'(in_operation);
      sel_r <= in_run_select;
      key_r <= in_key_value;
    end
  end

  // key memory, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= key_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  // head scan sequencer behind the registered read port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r     <= '0;
      n_r        <= '0;
      cand_vld_r <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      if (in_xfer) begin
        scan_r     <= '0;
        n_r        <= n_start;
        cand_vld_r <= 1'b0;
        found_r    <= 1'b0;
      end else if (state_r == S_SCAN) begin
        if (take_cand) begin
          found_r    <= 1'b1;
          best_run_r <= cand_run_r;
          best_key_r <= rd_data_r;
        end
        if (scan_busy) begin
          cand_vld_r <= head_elig;
          cand_run_r <= scan_run;
          scan_r     <= scan_r + 1'b1;
        end else begin
          cand_vld_r <= 1'b0;
        end
      end
    end
  end

  // run counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RUNS; i++) begin
        fill_r[i]   <= '0;
        rd_idx_r[i] <= '0;
      end
      out_result_valid <= 1'b0;
    end else begin
      if ((state_r == S_FINISH) && out_free) begin
        out_result_valid  <= 1'b1;
        out_value         <= '0;
        out_run           <= '0;
        out_valid         <= 1'b0;
        out_load_overflow <= 1'b0;
        case (op_r)
          kwsrm_pkg::OP_LOAD: begin
            if (load_ok) begin
              fill_r[sel_run] <= fill_r[sel_run] + 1'b1;
            end else begin
              out_load_overflow <= 1'b1;
            end
          end
          kwsrm_pkg::OP_POP: begin
            if (found_r) begin
              rd_idx_r[best_run_r] <= rd_idx_r[best_run_r] + 1'b1;
              out_value            <= best_key_r;
              out_run              <= kwsrm_pkg::OUT_RUN_W'(best_run_r);
              out_valid            <= 1'b1;
            end
          end
          kwsrm_pkg::OP_CLEAR: begin
            for (int i = 0; i < RUNS; i++) begin
              fill_r[i]   <= '0;
              rd_idx_r[i] <= '0;
            end
          end
          default: begin
          end
        endcase
      end else if (out_result_ready) begin
        out_result_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/kwsrm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwsrm_checker
// Port-level checks for the k-way sorted run merge block.
// ----------------------------------------------------------------------------
module kwsrm_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                out_result_valid,
  input  logic                                out_result_ready,
  input  logic signed [kwsrm_pkg::KEY_W-1:0]  out_value,
  input  logic [kwsrm_pkg::OUT_RUN_W-1:0]     out_run,
  input  logic                                out_valid,
  input  logic                                out_load_overflow
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_result_valid && !out_result_ready |=>
      out_result_valid && $stable(out_value) && $stable(out_run) &&
      $stable(out_valid) && $stable(out_load_overflow))
    else $error("result changed while stalled");

  // the block works on one item at a time
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after an input transfer");

  a_pop_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_result_valid && out_valid |-> !out_load_overflow)
    else $error("valid pop flagged as overflow");

  a_empty_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_result_valid && !out_valid |-> (out_value == '0) && (out_run == '0))
    else $error("invalid pop with nonzero payload");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_result_valid)
    else $error("result valid after reset");

endmodule

bind kway_sorted_run_merge kwsrm_checker u_kwsrm_checker (.*);
